>>> hw/rtl/ue2u_pkg.sv
// ----------------------------------------------------------------------------
// ue2u_pkg
// Item types, byte codes and the UTF-8 encoder shared by the escape decoder.
// ----------------------------------------------------------------------------
package ue2u_pkg;

   localparam int RUN_SLOTS = 6;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_item_type;

   // bytes caused by one input item, slot 0 goes out first
   typedef struct packed {
      logic [RUN_SLOTS-1:0][7:0] data;
      logic [2:0]                count;
   } run_type;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_HELD   = 2'd1;
   localparam logic [1:0] MODE_ESCAPE = 2'd2;

   localparam logic [1:0] PHASE_LEAD   = 2'd0;
   localparam logic [1:0] PHASE_SIGN   = 2'd1;
   localparam logic [1:0] PHASE_DIGITS = 2'd2;
   localparam logic [1:0] PHASE_DONE   = 2'd3;

   localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
   localparam logic [7:0] BYTE_U         = 8'h75;
   localparam logic [7:0] BYTE_SPACE     = 8'h20;
   localparam logic [7:0] BYTE_TAB       = 8'h09;
   localparam logic [7:0] BYTE_CR        = 8'h0D;
   localparam logic [7:0] BYTE_PLUS      = 8'h2B;
   localparam logic [7:0] BYTE_MINUS     = 8'h2D;
   localparam logic [7:0] BYTE_ZERO      = 8'h30;
   localparam logic [7:0] BYTE_NINE      = 8'h39;

   localparam logic [30:0] VALUE_MAX    = 31'h7FFF_FFFF;
   localparam logic [30:0] LIMIT_1BYTE  = 31'h0000_007F;
   localparam logic [30:0] LIMIT_2BYTE  = 31'h0000_07FF;
   localparam logic [30:0] LIMIT_3BYTE  = 31'h0000_FFFF;
   localparam logic [30:0] LIMIT_4BYTE  = 31'h001F_FFFF;
   localparam logic [30:0] LIMIT_5BYTE  = 31'h03FF_FFFF;
   localparam logic [16:0] NEG_BIAS     = 17'h1_0000;

   localparam logic [7:0] LEAD_2BYTE = 8'hC0;
   localparam logic [7:0] LEAD_3BYTE = 8'hE0;
   localparam logic [7:0] LEAD_4BYTE = 8'hF0;
   localparam logic [7:0] LEAD_5BYTE = 8'hF8;
   localparam logic [7:0] LEAD_6BYTE = 8'hFC;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   // legacy utf-8 up to 31 bits, zero gives an empty run
   function automatic run_type encode_utf8(input logic [30:0] v);
      run_type              r;
      logic [2:0]           len;
      logic [7:0]           lead;
      logic [35:0]          vx;
      logic [5:0][5:0]      chunk;
      vx = {5'b0, v};
      for (int j = 0; j < RUN_SLOTS; j++) begin
         chunk[j] = vx[6*j +: 6];
      end
      if (v <= LIMIT_1BYTE) begin
         len  = 3'd1;
         lead = {1'b0, v[6:0]};
      end else if (v <= LIMIT_2BYTE) begin
         len  = 3'd2;
         lead = LEAD_2BYTE | {3'b0, v[10:6]};
      end else if (v <= LIMIT_3BYTE) begin
         len  = 3'd3;
         lead = LEAD_3BYTE | {4'b0, v[15:12]};
      end else if (v <= LIMIT_4BYTE) begin
         len  = 3'd4;
         lead = LEAD_4BYTE | {5'b0, v[20:18]};
      end else if (v <= LIMIT_5BYTE) begin
         len  = 3'd5;
         lead = LEAD_5BYTE | {6'b0, v[25:24]};
      end else begin
         len  = 3'd6;
         lead = LEAD_6BYTE | {7'b0, v[30]};
      end
      r.data    = {RUN_SLOTS{BYTE_BACKSLASH}};
      r.data[0] = lead;
      for (int k = 1; k < RUN_SLOTS; k++) begin
         if (k < int'(len)) begin
            r.data[k] = CONT_MARK | {2'b0, chunk[3'(int'(len) - 1 - k)]};
         end
      end
      r.count = (v == '0) ? 3'd0 : len;
      return r;
   endfunction

endpackage

>>> hw/rtl/unicode_escape_to_utf8.sv
// ----------------------------------------------------------------------------
// unicode_escape_to_utf8
// Copies text bytes through and turns backslash-u decimal escapes into UTF-8.
// ----------------------------------------------------------------------------
//   channel   direction   item                          handshake
//   req_      in          in_byte, end_of_text          req_valid / req_stall
//   rsp_      out         out_byte, last_of_run         rsp_valid / rsp_stall
//
// each input item is parsed into a run of 0 to 6 bytes, which is registered in
// the run register; one byte leaves per cycle while rsp_stall is low, and an
// item that makes no bytes leaves the run register empty.
// a new item is taken while the last byte of the current run is delivered.
// synchronous reset clears the parse state and empties the run register.
// ----------------------------------------------------------------------------
module unicode_escape_to_utf8 (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ue2u_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ue2u_pkg::rsp_item_type rsp_item
);
   import ue2u_pkg::*;

   run_type run;
   logic    can_load;
   logic    take;

   assign req_stall = !can_load;
   assign take      = req_valid && can_load;

   ue2u_parse u_parse (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (req_item),
      .run   (run)
   );

   ue2u_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .run       (run),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

>>> hw/rtl/ue2u_parse.sv
// ----------------------------------------------------------------------------
// ue2u_parse
// Escape parser: holds the parse state and turns one input item into a run.
// ----------------------------------------------------------------------------
module ue2u_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  ue2u_pkg::req_item_type item,
   output ue2u_pkg::run_type      run
);
   import ue2u_pkg::*;

   logic [1:0]  mode_ff, mode_in;
   logic        started_ff, started_in;
   logic        neg_ff, neg_in;
   logic [1:0]  phase_ff, phase_in;
   logic [30:0] value_ff, value_in;

   logic [7:0]  b;
   logic        is_digit;
   logic        is_ws;
   logic [34:0] prod;
   logic [30:0] acc_value;
   logic        feed_neg;
   logic [1:0]  feed_phase;
   logic [30:0] feed_value;
   logic [30:0] final_value;

   assign b        = item.in_byte;
   assign is_digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
   assign is_ws    = (b == BYTE_SPACE) || ((b >= BYTE_TAB) && (b <= BYTE_CR));

   // value*10 + digit, saturating
   assign prod      = 35'({value_ff, 3'b000}) + 35'({value_ff, 1'b0}) + 35'(b - BYTE_ZERO);
   assign acc_value = (prod[34:31] != '0) ? VALUE_MAX : prod[30:0];

   always_comb begin
      feed_neg   = neg_ff;
      feed_phase = phase_ff;
      feed_value = value_ff;
      if (phase_ff != PHASE_DONE) begin
         if (is_digit) begin
            feed_value = acc_value;
            feed_phase = PHASE_DIGITS;
         end else if (phase_ff == PHASE_LEAD && (b == BYTE_PLUS || b == BYTE_MINUS)) begin
            feed_neg   = neg_ff | (b == BYTE_MINUS);
            feed_phase = PHASE_SIGN;
         end else if (!(phase_ff == PHASE_LEAD && is_ws)) begin
            feed_phase = PHASE_DONE;
         end
      end
   end

   // negative values fold to 65536 - magnitude, out of range gives nothing
   always_comb begin
      final_value = value_ff;
      if (neg_ff) begin
         if (value_ff == '0 || value_ff[30:16] != '0) begin
            final_value = '0;
         end else begin
            final_value = 31'(NEG_BIAS - {1'b0, value_ff[15:0]});
         end
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      started_in = started_ff;
      neg_in     = neg_ff;
      phase_in   = phase_ff;
      value_in   = value_ff;
      run.data   = {RUN_SLOTS{BYTE_BACKSLASH}};
      run.count  = 3'd0;
      unique case (mode_ff)
         MODE_HELD: begin
            if (b == BYTE_U) begin
               mode_in    = MODE_ESCAPE;
               started_in = 1'b0;
               neg_in     = 1'b0;
               phase_in   = PHASE_LEAD;
               value_in   = '0;
            end else begin
               run.count = 3'd1;
               if (b != BYTE_BACKSLASH) begin
                  run.data[1] = b;
                  run.count   = 3'd2;
                  mode_in     = MODE_NORMAL;
               end
            end
         end
         MODE_ESCAPE: begin
            if (started_ff && b == BYTE_SPACE) begin
               run        = encode_utf8(final_value);
               mode_in    = MODE_NORMAL;
               started_in = 1'b0;
               neg_in     = 1'b0;
               phase_in   = PHASE_LEAD;
               value_in   = '0;
            end else begin
               started_in = 1'b1;
               neg_in     = feed_neg;
               phase_in   = feed_phase;
               value_in   = feed_value;
            end
         end
         default: begin
            if (b == BYTE_BACKSLASH) begin
               mode_in = MODE_HELD;
            end else begin
               run.data[0] = b;
               run.count   = 3'd1;
               mode_in     = MODE_NORMAL;
            end
         end
      endcase
      // end of text flushes a held backslash, slots past the run already hold one
      if (item.end_of_text) begin
         if (mode_in == MODE_HELD) begin
            run.count = run.count + 3'd1;
         end
         mode_in    = MODE_NORMAL;
         started_in = 1'b0;
         neg_in     = 1'b0;
         phase_in   = PHASE_LEAD;
         value_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         started_ff <= 1'b0;
         neg_ff     <= 1'b0;
         phase_ff   <= PHASE_LEAD;
         value_ff   <= '0;
      end else if (take) begin
         mode_ff    <= mode_in;
         started_ff <= started_in;
         neg_ff     <= neg_in;
         phase_ff   <= phase_in;
         value_ff   <= value_in;
      end
   end

endmodule

>>> hw/rtl/ue2u_emit.sv
// ----------------------------------------------------------------------------
// ue2u_emit
// Run register: holds up to six bytes and hands them out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ue2u_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  ue2u_pkg::run_type      run,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ue2u_pkg::rsp_item_type rsp_item
);
   import ue2u_pkg::*;

   logic [RUN_SLOTS-1:0][7:0] data_ff;
   logic [2:0]                count_ff;
   logic [2:0]                idx_ff;
   logic                      is_last;
   logic                      fire;

   assign rsp_valid            = (count_ff != 3'd0);
   assign is_last              = (idx_ff == count_ff - 3'd1);
   assign fire                 = rsp_valid && !rsp_stall;
   assign can_load             = !rsp_valid || (fire && is_last);
   assign rsp_item.out_byte    = data_ff[idx_ff];
   assign rsp_item.last_of_run = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         idx_ff   <= 3'd0;
      end else if (take) begin
         count_ff <= run.count;
         idx_ff   <= 3'd0;
      end else if (fire) begin
         if (is_last) begin
            count_ff <= 3'd0;
            idx_ff   <= 3'd0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= run.data;
      end
   end

endmodule

>>> hw/rtl/ue2u_checker.sv
// ----------------------------------------------------------------------------
// ue2u_checker
// Port-level checks on the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ue2u_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input ue2u_pkg::req_item_type req_item,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input ue2u_pkg::rsp_item_type rsp_item
);
   import ue2u_pkg::*;

   logic [$bits(req_item_type)-1:0] req_bits;
   assign req_bits = req_item;

   // output register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item shown straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_item))
      else $error("stalled result item changed");

   // a run keeps going until its last byte
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_item.last_of_run |=> rsp_valid)
      else $error("run ended before its last byte");

   // no new item while a stalled run is still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && (req_valid || req_bits == req_bits) |-> req_stall)
      else $error("input item taken over a waiting run");

endmodule

bind unicode_escape_to_utf8 ue2u_checker u_ue2u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
